>>> hw/rtl/orbit_camera_pose_core_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ORBIT_CAMERA_POSE_CORE_MACROS_SVH
`define ORBIT_CAMERA_POSE_CORE_MACROS_SVH

// Clocked check, quiet while reset is held
`define OCP_CHK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also runs through reset
`define OCP_CHK_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> hw/rtl/ocp_pkg.sv
// ----------------------------------------------------------------------------
// ocp_pkg
// Types, constants and small arithmetic helpers of the orbit camera core.
// ----------------------------------------------------------------------------
`default_nettype none

package ocp_pkg;

    // Event codes carried in the action field
    typedef enum logic [1:0] {
        ACT_OTHER  = 2'd0,
        ACT_WHEEL  = 2'd1,
        ACT_MOTION = 2'd2,
        ACT_RESET  = 2'd3
    } t_action;

    // Configuration register indexes
    localparam logic [7:0] CFG_ZOOM  = 8'd0;
    localparam logic [7:0] CFG_PITCH = 8'd1;

    localparam logic signed [31:0] ZOOM_RESET  = 32'sd655360;
    localparam logic signed [15:0] PITCH_RESET = 16'sd0;
    localparam logic signed [17:0] PITCH_LIM   = 18'sd22784;

    // Angles in degrees, Q16.16
    localparam logic signed [26:0] DEG360 = 27'sd23592960;
    localparam logic signed [26:0] DEG180 = 27'sd11796480;
    localparam logic signed [26:0] DEG90  = 27'sd5898240;

    localparam logic signed [32:0] CORDIC_K = 33'sd652032874;
    localparam logic [32:0] RECIP10 = 33'd429496730;

    typedef struct packed {
        t_action            action;
        logic signed [15:0] wheel_amount;
        logic signed [15:0] move_x;
        logic signed [15:0] move_y;
        logic               button_left;
        logic               button_middle;
        logic               button_right;
        logic signed [31:0] char_x;
        logic signed [31:0] char_y;
        logic signed [31:0] char_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] cam_x;
        logic signed [31:0] cam_y;
        logic signed [31:0] cam_z;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic signed [15:0] pitch_now;
        logic signed [31:0] zoom_now;
        logic        [24:0] orbit_now;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  reg_index;
        logic [31:0] wdata;
    } t_cfg_word;

    // Snapshot handed from the front end to the back end
    typedef struct packed {
        logic signed [31:0] zoom;
        logic signed [15:0] pitch;
        logic        [24:0] orbit;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
    } t_job;

    typedef struct packed {
        logic               neg;
        logic signed [26:0] ang;
    } t_red;

    typedef enum logic [1:0] {
        FE_IDLE,
        FE_CALC,
        FE_PUSH
    } t_fe_state;

    typedef enum logic [3:0] {
        BE_IDLE,
        BE_COR,
        BE_MH,
        BE_MV,
        BE_MX,
        BE_MZ,
        BE_GEO,
        BE_NORM,
        BE_SQ0,
        BE_SQ1,
        BE_SQ2,
        BE_SQ3,
        BE_SQRT,
        BE_DINIT,
        BE_DIV,
        BE_OUT
    } t_be_state;

    // atan(2^-i) in degrees, Q16.16
    function automatic logic [21:0] atan_deg(input logic [4:0] i);
        case (i)
            5'd0:    return 22'd2949120;
            5'd1:    return 22'd1740967;
            5'd2:    return 22'd919879;
            5'd3:    return 22'd466945;
            5'd4:    return 22'd234379;
            5'd5:    return 22'd117304;
            5'd6:    return 22'd58666;
            5'd7:    return 22'd29335;
            5'd8:    return 22'd14668;
            5'd9:    return 22'd7334;
            5'd10:   return 22'd3667;
            5'd11:   return 22'd1833;
            5'd12:   return 22'd917;
            5'd13:   return 22'd458;
            5'd14:   return 22'd229;
            5'd15:   return 22'd115;
            5'd16:   return 22'd57;
            5'd17:   return 22'd29;
            5'd18:   return 22'd14;
            5'd19:   return 22'd7;
            5'd20:   return 22'd4;
            5'd21:   return 22'd2;
            5'd22:   return 22'd1;
            default: return 22'd0;
        endcase
    endfunction

    // Floor of n/10 by reciprocal multiply, exact below 2^30
    function automatic logic [26:0] div10(input logic [29:0] n);
        logic [62:0] p;
        p = 63'(n) * 63'(RECIP10);
        return p[58:32];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        if (v > 36'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -36'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [15:0] clamp_pitch(input logic signed [17:0] v);
        if (v > PITCH_LIM) begin
            return PITCH_LIM[15:0];
        end else if (v < -PITCH_LIM) begin
            return 16'(-PITCH_LIM);
        end
        return v[15:0];
    endfunction

    // Fold an angle in (-180, 360) degrees into +-90 with a sign flag
    function automatic t_red reduce_angle(input logic signed [26:0] a);
        t_red               r;
        logic signed [26:0] t;
        t     = a;
        r.neg = 1'b0;
        if (t >= DEG180) begin
            t = t - DEG360;
        end
        if (t > DEG90) begin
            t     = t - DEG180;
            r.neg = 1'b1;
        end else if (t < -DEG90) begin
            t     = t + DEG180;
            r.neg = 1'b1;
        end
        r.ang = t;
        return r;
    endfunction

    // Round a Q2.30 product back to the operand format
    function automatic logic signed [34:0] rnd30(input logic signed [65:0] p);
        logic signed [65:0] t;
        t = p + 66'sd536870912;
        return 35'(t >>> 30);
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ocp_chan_if.sv
// ----------------------------------------------------------------------------
// ocp_chan_if
// Valid/ready channel carrying one payload word of type T.
// ----------------------------------------------------------------------------
`default_nettype none

interface ocp_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/orbit_camera_pose_core.sv
// Per item the back end runs two CORDIC passes, normalising shifts, the 32-step square root
// and the 15-step dividers; a zero view vector skips the square root and the dividers.
// The back end starts a new item only after its last result is taken; the front end takes
// one event at a time, ready only while idle, and waits while the two-deep queue is full.
// Reset (synchronous, active low): zoom 10.0, pitch 0, orbit 0, queue empty, no result.
// ----------------------------------------------------------------------------
// orbit_camera_pose_core
// Third-person orbit camera: event front end, job queue and pose back end.
// ----------------------------------------------------------------------------
`default_nettype none

module orbit_camera_pose_core #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ocp_chan_if.sink    i_in,
    ocp_chan_if.source  o_out,
    ocp_chan_if.sink    i_cfg
);

    ocp_pkg::t_job push_job, pop_job;
    logic          push, pop, full, empty;

    // Event handling and camera state
    ocp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .o_job   (push_job),
        .o_push  (push),
        .i_full  (full)
    );

    // Queue between the two halves
    ocp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_empty (empty)
    );

    // Pose computation
    ocp_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (pop_job),
        .i_empty (empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

>>> hw/rtl/ocp_front.sv
// ----------------------------------------------------------------------------
// ocp_front
// Takes events and register writes, updates zoom, pitch and orbit angle,
// and pushes a snapshot of the new state into the job queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ocp_front (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    ocp_chan_if.sink        i_in,
    ocp_chan_if.sink        i_cfg,
    output ocp_pkg::t_job   o_job,
    output logic            o_push,
    input  wire logic       i_full
);

    ocp_pkg::t_fe_state r_state, n_state;
    ocp_pkg::t_in_item  r_item;

    logic signed [31:0] r_zoom;
    logic signed [15:0] r_pitch;
    logic        [24:0] r_orbit;
    logic signed [27:0] r_dz, r_dp, r_do;

    logic        [15:0] abs_w, abs_x, abs_y;
    logic        [26:0] q_w, q_x, q_y;
    logic signed [32:0] zsum;
    logic signed [17:0] psum;
    logic signed [28:0] osum, owrap1, owrap2;
    logic signed [28:0] deg360_w;
    logic signed [31:0] n_zoom;
    logic signed [15:0] n_pitch;
    logic        [24:0] n_orbit;
    logic               cfg_fire;

    assign deg360_w = 29'(ocp_pkg::DEG360);
    assign cfg_fire = i_cfg.valid && i_cfg.ready;

    // Magnitudes and rounded tenths of the event amounts
    always_comb begin
        abs_w = r_item.wheel_amount[15] ? 16'(-r_item.wheel_amount) : 16'(r_item.wheel_amount);
        abs_x = r_item.move_x[15] ? 16'(-r_item.move_x) : 16'(r_item.move_x);
        abs_y = r_item.move_y[15] ? 16'(-r_item.move_y) : 16'(r_item.move_y);
        q_w   = ocp_pkg::div10({6'd0, abs_w, 8'd0} + 30'd5);
        q_y   = ocp_pkg::div10({10'd0, abs_y, 4'd0} + 30'd5);
        q_x   = ocp_pkg::div10(30'({abs_x, 13'd0}) + 30'({abs_x, 12'd0}) + 30'd5);
    end

    // Apply the deltas to the state
    always_comb begin
        n_zoom  = r_zoom;
        n_pitch = r_pitch;
        n_orbit = r_orbit;
        zsum    = 33'(r_zoom) + 33'(r_dz);
        psum    = 18'(r_pitch) + 18'(r_dp);
        osum    = $signed({4'd0, r_orbit}) + 29'(r_do);
        owrap1  = osum[28] ? osum + deg360_w :
                  (osum >= deg360_w ? osum - deg360_w : osum);
        owrap2  = owrap1[28] ? owrap1 + deg360_w :
                  (owrap1 >= deg360_w ? owrap1 - deg360_w : owrap1);
        case (r_item.action)
            ocp_pkg::ACT_WHEEL: begin
                n_zoom = ocp_pkg::sat32(36'(zsum));
            end
            ocp_pkg::ACT_MOTION: begin
                if (r_item.button_right || r_item.button_middle) begin
                    n_pitch = ocp_pkg::clamp_pitch(psum);
                end
                if (r_item.button_left || r_item.button_middle) begin
                    n_orbit = owrap2[24:0];
                end
            end
            ocp_pkg::ACT_RESET: begin
                n_orbit = '0;
            end
            default: begin
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ocp_pkg::FE_IDLE: if (i_in.valid) n_state = ocp_pkg::FE_CALC;
            ocp_pkg::FE_CALC: n_state = ocp_pkg::FE_PUSH;
            ocp_pkg::FE_PUSH: if (!i_full) n_state = ocp_pkg::FE_IDLE;
            default:          n_state = ocp_pkg::FE_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        i_in.ready  = (r_state == ocp_pkg::FE_IDLE);
        i_cfg.ready = 1'b1;
        o_push      = (r_state == ocp_pkg::FE_PUSH) && !i_full;
        o_job.zoom  = n_zoom;
        o_job.pitch = n_pitch;
        o_job.orbit = n_orbit;
        o_job.cx    = r_item.char_x;
        o_job.cy    = r_item.char_y;
        o_job.cz    = r_item.char_z;
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ocp_pkg::FE_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Camera state and register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zoom  <= ocp_pkg::ZOOM_RESET;
            r_pitch <= ocp_pkg::PITCH_RESET;
            r_orbit <= '0;
        end else if (o_push) begin
            r_zoom  <= n_zoom;
            r_pitch <= n_pitch;
            r_orbit <= n_orbit;
        end else if (cfg_fire) begin
            if (i_cfg.data.reg_index == ocp_pkg::CFG_ZOOM) begin
                r_zoom <= i_cfg.data.wdata;
            end else if (i_cfg.data.reg_index == ocp_pkg::CFG_PITCH) begin
                r_pitch <= ocp_pkg::clamp_pitch(18'($signed(i_cfg.data.wdata[15:0])));
            end
        end
    end

    // Latch the event and its deltas
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item <= i_in.data;
        end
        if (r_state == ocp_pkg::FE_CALC) begin
            r_dz <= r_item.wheel_amount[15] ? $signed({1'b0, q_w}) : -$signed({1'b0, q_w});
            r_dp <= r_item.move_y[15] ? $signed({1'b0, q_y}) : -$signed({1'b0, q_y});
            r_do <= r_item.move_x[15] ? -$signed({1'b0, q_x}) : $signed({1'b0, q_x});
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/ocp_fifo.sv
// ----------------------------------------------------------------------------
// ocp_fifo
// Two-entry job queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ocp_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  ocp_pkg::t_job       i_job,
    output logic                o_full,
    input  wire logic           i_pop,
    output ocp_pkg::t_job       o_job,
    output logic                o_empty
);

    ocp_pkg::t_job r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // Store the pushed word
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/ocp_back.sv
// ----------------------------------------------------------------------------
// ocp_back
// Sequencer that turns one job into a camera pose: shared CORDIC, shared
// multiplier, normalising shifter, bit-serial square root and three
// bit-serial dividers.
// ----------------------------------------------------------------------------
`default_nettype none

module ocp_back #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  ocp_pkg::t_job   i_job,
    input  wire logic       i_empty,
    output logic            o_pop,
    ocp_chan_if.source      o_out
);

    localparam int IW = $clog2(CORDIC_STEPS + 1);
    localparam logic [IW-1:0] LAST_STEP = IW'(CORDIC_STEPS);

    ocp_pkg::t_be_state r_state, n_state;
    ocp_pkg::t_job      r_job;

    logic signed [32:0] r_x, r_y;
    logic signed [26:0] r_z;
    logic               r_neg, r_pass;
    logic [IW-1:0]      r_i;
    logic signed [31:0] r_ps, r_pc;
    logic signed [65:0] r_prod;
    logic signed [34:0] r_h, r_v, r_offx;
    logic signed [31:0] r_cam [3];
    logic        [34:0] r_a [3];
    logic        [2:0]  r_dneg;
    logic               r_zero;
    logic        [63:0] r_sv, r_sr;
    logic        [4:0]  r_sj;
    logic        [31:0] r_len;
    logic        [31:0] r_rem [3];
    logic        [14:0] r_num [3];
    logic        [14:0] r_q [3];
    logic        [3:0]  r_k;

    logic signed [33:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [32:0] xs, ys;
    logic signed [26:0] at;
    logic signed [32:0] sin_v, cos_v;
    logic signed [34:0] offz;
    logic        [34:0] m;
    logic        [63:0] sb, sq_try;
    ocp_pkg::t_red      red_p, red_o;
    logic signed [15:0] dir_v [3];

    // CORDIC step terms
    always_comb begin
        xs    = r_x >>> r_i;
        ys    = r_y >>> r_i;
        at    = $signed({5'd0, ocp_pkg::atan_deg(5'(r_i))});
        sin_v = r_neg ? -r_y : r_y;
        cos_v = r_neg ? -r_x : r_x;
        red_p = ocp_pkg::reduce_angle($signed({{3{i_job.pitch[15]}}, i_job.pitch, 8'd0}));
        red_o = ocp_pkg::reduce_angle($signed({2'd0, r_job.orbit}));
    end

    // Largest magnitude, square-root trial, offset rounding
    always_comb begin
        m = r_a[0];
        if (r_a[1] > m) m = r_a[1];
        if (r_a[2] > m) m = r_a[2];
        sb     = 64'd1 << {r_sj, 1'b0};
        sq_try = r_sr + sb;
        offz   = ocp_pkg::rnd30(r_prod);
    end

    // Multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ocp_pkg::BE_MH: begin mul_a = 34'(r_job.zoom); mul_b = r_pc; end
            ocp_pkg::BE_MV: begin mul_a = 34'(r_job.zoom); mul_b = r_ps; end
            ocp_pkg::BE_MX: begin mul_a = 34'(r_h); mul_b = 32'(sin_v); end
            ocp_pkg::BE_MZ: begin mul_a = 34'(r_h); mul_b = 32'(cos_v); end
            ocp_pkg::BE_SQ0: begin
                mul_a = $signed({4'd0, r_a[0][29:0]});
                mul_b = $signed({2'd0, r_a[0][29:0]});
            end
            ocp_pkg::BE_SQ1: begin
                mul_a = $signed({4'd0, r_a[1][29:0]});
                mul_b = $signed({2'd0, r_a[1][29:0]});
            end
            ocp_pkg::BE_SQ2: begin
                mul_a = $signed({4'd0, r_a[2][29:0]});
                mul_b = $signed({2'd0, r_a[2][29:0]});
            end
            default: begin
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ocp_pkg::BE_IDLE: if (!i_empty) n_state = ocp_pkg::BE_COR;
            ocp_pkg::BE_COR:  if (r_i == LAST_STEP && r_pass) n_state = ocp_pkg::BE_MH;
            ocp_pkg::BE_MH:   n_state = ocp_pkg::BE_MV;
            ocp_pkg::BE_MV:   n_state = ocp_pkg::BE_MX;
            ocp_pkg::BE_MX:   n_state = ocp_pkg::BE_MZ;
            ocp_pkg::BE_MZ:   n_state = ocp_pkg::BE_GEO;
            ocp_pkg::BE_GEO:  n_state = ocp_pkg::BE_NORM;
            ocp_pkg::BE_NORM: begin
                if (m == '0) begin
                    n_state = ocp_pkg::BE_OUT;
                end else if (m[34:30] == '0 && m[29]) begin
                    n_state = ocp_pkg::BE_SQ0;
                end
            end
            ocp_pkg::BE_SQ0:  n_state = ocp_pkg::BE_SQ1;
            ocp_pkg::BE_SQ1:  n_state = ocp_pkg::BE_SQ2;
            ocp_pkg::BE_SQ2:  n_state = ocp_pkg::BE_SQ3;
            ocp_pkg::BE_SQ3:  n_state = ocp_pkg::BE_SQRT;
            ocp_pkg::BE_SQRT: if (r_sj == 5'd0) n_state = ocp_pkg::BE_DINIT;
            ocp_pkg::BE_DINIT: n_state = ocp_pkg::BE_DIV;
            ocp_pkg::BE_DIV:  if (r_k == 4'd14) n_state = ocp_pkg::BE_OUT;
            ocp_pkg::BE_OUT:  if (o_out.ready) n_state = ocp_pkg::BE_IDLE;
            default:          n_state = ocp_pkg::BE_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dir_v[k] = r_zero ? 16'sd0 :
                       (r_dneg[k] ? -$signed({1'b0, r_q[k]}) : $signed({1'b0, r_q[k]}));
        end
        o_pop                = (r_state == ocp_pkg::BE_IDLE) && !i_empty;
        o_out.valid          = (r_state == ocp_pkg::BE_OUT);
        o_out.data.cam_x     = r_cam[0];
        o_out.data.cam_y     = r_cam[1];
        o_out.data.cam_z     = r_cam[2];
        o_out.data.dir_x     = dir_v[0];
        o_out.data.dir_y     = dir_v[1];
        o_out.data.dir_z     = dir_v[2];
        o_out.data.pitch_now = r_job.pitch;
        o_out.data.zoom_now  = r_job.zoom;
        o_out.data.orbit_now = r_job.orbit;
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ocp_pkg::BE_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (r_state)
            ocp_pkg::BE_IDLE: begin
                // load the job and start the pitch rotation
                r_job  <= i_job;
                r_x    <= ocp_pkg::CORDIC_K;
                r_y    <= '0;
                r_z    <= red_p.ang;
                r_neg  <= red_p.neg;
                r_i    <= '0;
                r_pass <= 1'b0;
            end
            ocp_pkg::BE_COR: begin
                if (r_i == LAST_STEP && !r_pass) begin
                    // keep pitch results and start the orbit rotation
                    r_ps   <= 32'(sin_v);
                    r_pc   <= 32'(cos_v);
                    r_x    <= ocp_pkg::CORDIC_K;
                    r_y    <= '0;
                    r_z    <= red_o.ang;
                    r_neg  <= red_o.neg;
                    r_i    <= '0;
                    r_pass <= 1'b1;
                end else if (r_i != LAST_STEP) begin
                    r_i <= r_i + 1'b1;
                    if (!r_z[26]) begin
                        r_x <= r_x - ys;
                        r_y <= r_y + xs;
                        r_z <= r_z - at;
                    end else begin
                        r_x <= r_x + ys;
                        r_y <= r_y - xs;
                        r_z <= r_z + at;
                    end
                end
                if (r_i == LAST_STEP && r_pass) begin
                    r_x <= cos_v;
                    r_y <= sin_v;
                end
            end
            ocp_pkg::BE_MH: begin
                // hold orbit sin and cos for the next two products
                r_neg <= 1'b0;
            end
            ocp_pkg::BE_MV: r_h    <= ocp_pkg::rnd30(r_prod);
            ocp_pkg::BE_MX: r_v    <= ocp_pkg::rnd30(r_prod);
            ocp_pkg::BE_MZ: r_offx <= ocp_pkg::rnd30(r_prod);
            ocp_pkg::BE_GEO: begin
                // view vector, its magnitudes and the saturated camera position
                r_cam[0] <= ocp_pkg::sat32(36'(r_job.cx) - 36'(r_offx));
                r_cam[1] <= ocp_pkg::sat32(36'(r_job.cy) + 36'(r_v) + 36'sd131072);
                r_cam[2] <= ocp_pkg::sat32(36'(r_job.cz) + 36'(offz));
                r_dneg[0] <= r_offx[34];
                r_a[0]    <= r_offx[34] ? 35'(-r_offx) : 35'(r_offx);
                r_dneg[1] <= (35'sd196608 - r_v) < 0;
                r_a[1]    <= ((35'sd196608 - r_v) < 0) ? 35'(r_v - 35'sd196608) :
                                                         35'(35'sd196608 - r_v);
                r_dneg[2] <= (offz > 0);
                r_a[2]    <= offz[34] ? 35'(-offz) : 35'(offz);
                r_zero    <= 1'b0;
            end
            ocp_pkg::BE_NORM: begin
                if (m == '0) begin
                    r_zero <= 1'b1;
                end else if (m[34:30] != '0) begin
                    for (int k = 0; k < 3; k++) r_a[k] <= r_a[k] >> 1;
                end else if (m[29:25] == '0) begin
                    for (int k = 0; k < 3; k++) r_a[k] <= r_a[k] << 4;
                end else if (!m[29]) begin
                    for (int k = 0; k < 3; k++) r_a[k] <= r_a[k] << 1;
                end
            end
            ocp_pkg::BE_SQ1: r_sv <= 64'(r_prod);
            ocp_pkg::BE_SQ2: r_sv <= r_sv + 64'(r_prod);
            ocp_pkg::BE_SQ3: begin
                r_sv <= r_sv + 64'(r_prod);
                r_sr <= '0;
                r_sj <= 5'd31;
            end
            ocp_pkg::BE_SQRT: begin
                // one result bit per cycle
                if (r_sv >= sq_try) begin
                    r_sv <= r_sv - sq_try;
                    r_sr <= (r_sr >> 1) + sb;
                end else begin
                    r_sr <= r_sr >> 1;
                end
                r_sj <= r_sj - 5'd1;
            end
            ocp_pkg::BE_DINIT: begin
                r_len <= r_sr[31:0];
                r_k   <= '0;
                for (int k = 0; k < 3; k++) begin
                    r_rem[k] <= 32'(({15'd0, r_a[k][29:0]} << 14) + 45'(r_sr[31:1]) >> 15);
                    r_num[k] <= 15'(({15'd0, r_a[k][29:0]} << 14) + 45'(r_sr[31:1]));
                    r_q[k]   <= '0;
                end
            end
            ocp_pkg::BE_DIV: begin
                // restoring divide, one quotient bit per lane per cycle
                r_k <= r_k + 4'd1;
                for (int k = 0; k < 3; k++) begin
                    if ({r_rem[k], r_num[k][14]} >= {1'b0, r_len}) begin
                        r_rem[k] <= 32'({r_rem[k], r_num[k][14]} - {1'b0, r_len});
                        r_q[k]   <= {r_q[k][13:0], 1'b1};
                    end else begin
                        r_rem[k] <= {r_rem[k][30:0], r_num[k][14]};
                        r_q[k]   <= {r_q[k][13:0], 1'b0};
                    end
                    r_num[k] <= {r_num[k][13:0], 1'b0};
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/ocp_checker.sv
// ----------------------------------------------------------------------------
// ocp_checker
// Port-level checks of the orbit camera core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "orbit_camera_pose_core_macros.svh"

module ocp_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input ocp_pkg::t_out_item      i_out_data
);

    // Hold a result until taken
    `OCP_CHK(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid, "result dropped before taken")

    // No result straight after reset
    `OCP_CHK_RST(a_rst_quiet, !i_rst_n |=> !i_out_valid, "result shown after reset")

    // Direction stays a unit vector component
    `OCP_CHK(a_dir_range, i_out_valid |-> (i_out_data.dir_x <= 16'sd16384 && i_out_data.dir_x >= -16'sd16384 && i_out_data.dir_y <= 16'sd16384 && i_out_data.dir_y >= -16'sd16384 && i_out_data.dir_z <= 16'sd16384 && i_out_data.dir_z >= -16'sd16384), "direction out of range")

    // Orbit wrapped below 360 degrees
    `OCP_CHK(a_orbit_wrap, i_out_valid |-> i_out_data.orbit_now < 25'd23592960, "orbit not wrapped")

    // Pitch inside the clamp
    `OCP_CHK(a_pitch_clamp, i_out_valid |-> (i_out_data.pitch_now <= 16'sd22784 && i_out_data.pitch_now >= -16'sd22784), "pitch outside clamp")

endmodule

bind orbit_camera_pose_core ocp_checker u_ocp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

`default_nettype wire
